### hw/rtl/rk4_driven_damped_oscillator_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the RK4 oscillator unit
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RK4_DRIVEN_DAMPED_OSCILLATOR_UNIT_ASSERT_SVH
`define RK4_DRIVEN_DAMPED_OSCILLATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RK4DO_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RK4DO_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/rk4do_pkg.sv
// ----------------------------------------------------------------------------
// rk4do_pkg
// Shared types and constants of the RK4 driven damped oscillator unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rk4do_pkg;

    localparam int ADDR_W    = 5;
    localparam int CNT_W     = 7;
    localparam int TABLE_LEN = 30;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_INV_MASS  = 3'd0;
    localparam logic [2:0] REG_STIFFNESS = 3'd1;
    localparam logic [2:0] REG_DAMPING   = 3'd2;
    localparam logic [2:0] REG_F_AMP     = 3'd3;
    localparam logic [2:0] REG_F_FREQ    = 3'd4;
    localparam logic [2:0] REG_TIME_STEP = 3'd5;
    localparam logic [2:0] REG_INIT_POS  = 3'd6;
    localparam logic [2:0] REG_INIT_VEL  = 3'd7;

    // Reset values of the registers.
    localparam logic [30:0]        RST_INV_MASS  = 31'd16777216;
    localparam logic [30:0]        RST_STIFFNESS = 31'd16777216;
    localparam logic [30:0]        RST_DAMPING   = 31'd1677722;
    localparam logic signed [31:0] RST_F_AMP     = 32'sd16777216;
    localparam logic [30:0]        RST_F_FREQ    = 31'd0;
    localparam logic [24:0]        RST_TIME_STEP = 25'd16777;
    localparam logic signed [31:0] RST_INIT_POS  = 32'sd67108864;
    localparam logic signed [31:0] RST_INIT_VEL  = 32'sd0;

    // Angle constants in Q32 and the CORDIC start gain in Q30.
    localparam logic [63:0] TWO_PI_Q32      = 64'h6_487E_D511;
    localparam logic [63:0] PI_Q32          = 64'h3_243F_6A88;
    localparam logic [63:0] HALF_PI_Q32     = 64'h1_921F_B544;
    localparam logic [33:0] CORDIC_GAIN_Q30 = 34'h026DD3B6A;

    typedef struct packed {
        logic               clip;
        logic signed [31:0] val;
    } sat_t;

    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] r;
        unique case (idx)
            5'd0:  r = 30'h3243F6A8;
            5'd1:  r = 30'h1DAC6705;
            5'd2:  r = 30'h0FADBAFC;
            5'd3:  r = 30'h07F56EA6;
            5'd4:  r = 30'h03FEAB76;
            5'd5:  r = 30'h01FFD55B;
            5'd6:  r = 30'h00FFFAAA;
            5'd7:  r = 30'h007FFF55;
            5'd8:  r = 30'h003FFFEA;
            5'd9:  r = 30'h001FFFFD;
            5'd10: r = 30'h000FFFFF;
            5'd11: r = 30'h0007FFFF;
            5'd12: r = 30'h0003FFFF;
            5'd13: r = 30'h0001FFFF;
            5'd14: r = 30'h0000FFFF;
            5'd15: r = 30'h00007FFF;
            5'd16: r = 30'h00003FFF;
            5'd17: r = 30'h00001FFF;
            5'd18: r = 30'h00000FFF;
            5'd19: r = 30'h000007FF;
            5'd20: r = 30'h000003FF;
            5'd21: r = 30'h000001FF;
            5'd22: r = 30'h000000FF;
            5'd23: r = 30'h0000007F;
            5'd24: r = 30'h0000003F;
            5'd25: r = 30'h0000001F;
            5'd26: r = 30'h0000000F;
            5'd27: r = 30'h00000008;
            5'd28: r = 30'h00000004;
            5'd29: r = 30'h00000002;
            default: r = 30'h00000000;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/rk4_driven_damped_oscillator_unit.sv
// ----------------------------------------------------------------------------
// rk4_driven_damped_oscillator_unit
// Spring-mass-damper with cosine forcing, advanced by classical RK4 steps.
// ----------------------------------------------------------------------------
// Each word on the input stream either restarts the simulation (restart = 1,
// no output) or advances it by one RK4 step. Before every SAMPLE_EVERY-th
// step a word with time, position, velocity, force and a clipping flag is
// sent. All products go through one bit-serial multiplier; the angle
// reduction and the division by six are bit-serial and the CORDIC is
// iterative. A step that sends a sample word also waits until the output
// register is free. The multiplier takes one multiplier bit per cycle. No
// new word is taken during a step. The user must write configuration through
// the APB port only while the unit is idle; the unit does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rk4_driven_damped_oscillator_unit_assert.svh"

module rk4_driven_damped_oscillator_unit #(
    parameter int SAMPLE_EVERY = 100,
    parameter int FRAC_BITS    = 24,
    parameter int CORDIC_STEPS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // slave stream: [0] restart, [7:1] zero
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,
    // master stream: [39:0] sample_time, [71:40] position, [103:72] velocity,
    // [135:104] force_res, [136] saturated, [143:137] zero
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [143:0]                  m_axis_tdata,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rk4do_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int AW      = 33;
    localparam int BW      = 41;
    localparam int PW      = AW + BW;
    localparam int ACC_W   = 65 - FRAC_BITS;
    localparam int ANG_W   = 71 - FRAC_BITS;
    localparam int TP_W    = FRAC_BITS + 3;
    localparam int R_W     = TP_W + 1;
    localparam int ZW      = 34;
    localparam int SUM_W   = 35;
    localparam int NSTEP   = (CORDIC_STEPS < rk4do_pkg::TABLE_LEN) ?
                             CORDIC_STEPS : rk4do_pkg::TABLE_LEN;

    localparam logic [63:0] TWO_PI_64  = (rk4do_pkg::TWO_PI_Q32 +
        (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    localparam logic [63:0] PI_64      = (rk4do_pkg::PI_Q32 +
        (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    localparam logic [63:0] HALF_PI_64 = (rk4do_pkg::HALF_PI_Q32 +
        (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);

    localparam logic [TP_W:0]           TWO_PI_U = TWO_PI_64[TP_W:0];
    localparam logic signed [R_W-1:0]   TWO_PI_S = $signed(TWO_PI_64[R_W-1:0]);
    localparam logic signed [R_W-1:0]   PI_S     = $signed(PI_64[R_W-1:0]);
    localparam logic signed [R_W-1:0]   HALF_S   = $signed(HALF_PI_64[R_W-1:0]);

    localparam logic signed [PW-1:0] RND_HALF = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
    localparam logic signed [PW-1:0] S32_MAX  = PW'(32'sh7FFF_FFFF);
    localparam logic signed [PW-1:0] S32_MIN  = -S32_MAX - PW'(1);
    localparam logic signed [ZW-1:0] COS_RND  = {{(ZW-1){1'b0}}, 1'b1} << (29 - FRAC_BITS);
    localparam logic signed [ZW-1:0] ONE_Q    = {{(ZW-1){1'b0}}, 1'b1} << FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_MUL, S_MOD, S_CORD, S_OUT, S_DIV
    } state_t;

    typedef enum logic [2:0] {
        OP_ANG, OP_FRC, OP_KX, OP_CV, OP_IM, OP_ADT, OP_VDT
    } op_t;

    function automatic rk4do_pkg::sat_t sat32c(input logic signed [PW-1:0] v);
        rk4do_pkg::sat_t r;
        if (v > S32_MAX) begin
            r.clip = 1'b1;
            r.val  = 32'sh7FFF_FFFF;
        end else if (v < S32_MIN) begin
            r.clip = 1'b1;
            r.val  = 32'sh8000_0000;
        end else begin
            r.clip = 1'b0;
            r.val  = v[31:0];
        end
        return r;
    endfunction

    // configuration registers
    logic [30:0]        inv_mass_reg, stiff_reg, damp_reg, f_freq_reg;
    logic signed [31:0] f_amp_reg, init_pos_reg, init_vel_reg;
    logic [24:0]        dt_reg;

    // simulation state
    logic signed [31:0]       pos_reg, vel_reg;
    logic [39:0]              sim_time_reg;
    logic [rk4do_pkg::CNT_W-1:0] countdown_reg;
    logic                     clip_flag_reg;

    // step control and working values
    state_t             state_reg;
    op_t                op_reg;
    logic [1:0]         stage_reg;
    logic               sample_reg, step_clip_reg;
    logic [39:0]        tm_reg, te_reg, ts_reg;
    logic signed [31:0] xw_reg, vw_reg, force_reg, sum_reg, a_reg, kv_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [SUM_W-1:0] sumx_reg, sumv_reg;
    logic               negx_reg, negv_reg;
    logic [SUM_W-1:0]   divx_reg, divv_reg;
    logic [2:0]         remx_reg, remv_reg;
    logic [5:0]         cnt_reg;

    // serial multiplier
    logic signed [PW-1:0] m_reg, p_reg;
    logic signed [BW-1:0] b_reg;

    // angle reduction and CORDIC
    logic [ANG_W-1:0]     ang_reg;
    logic [TP_W-1:0]      rem_reg;
    logic signed [ZW-1:0] cx_reg, cy_reg, cz_reg, cos_reg;
    logic                 cneg_reg;

    // output word
    logic               out_valid_reg, out_sat_reg;
    logic [39:0]        out_time_reg;
    logic signed [31:0] out_pos_reg, out_vel_reg, out_force_reg;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_comb
    begin
        unique case (cfg_idx)
            rk4do_pkg::REG_INV_MASS:  prdata = {1'b0, inv_mass_reg};
            rk4do_pkg::REG_STIFFNESS: prdata = {1'b0, stiff_reg};
            rk4do_pkg::REG_DAMPING:   prdata = {1'b0, damp_reg};
            rk4do_pkg::REG_F_AMP:     prdata = f_amp_reg;
            rk4do_pkg::REG_F_FREQ:    prdata = {1'b0, f_freq_reg};
            rk4do_pkg::REG_TIME_STEP: prdata = {7'b0, dt_reg};
            rk4do_pkg::REG_INIT_POS:  prdata = init_pos_reg;
            rk4do_pkg::REG_INIT_VEL:  prdata = init_vel_reg;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic                 in_acc, restart;
    logic [40:0]          tm_sum, te_sum;
    logic signed [AW-1:0] op_a;
    logic signed [BW-1:0] op_b;
    logic                 mul_last;
    logic signed [PW-1:0] p_next, rnd_val;
    rk4do_pkg::sat_t      rs;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign restart = s_axis_tdata[0];
    assign tm_sum  = {1'b0, sim_time_reg} + 41'({1'b0, dt_reg[24:1]});
    assign te_sum  = {1'b0, sim_time_reg} + 41'(dt_reg);

    always_comb
    begin
        unique case (op_reg)
            OP_ANG:
            begin
                op_a = {2'b0, f_freq_reg};
                op_b = {1'b0, ts_reg};
            end
            OP_FRC:
            begin
                op_a = AW'(f_amp_reg);
                op_b = BW'(cos_reg);
            end
            OP_KX:
            begin
                op_a = {2'b0, stiff_reg};
                op_b = BW'(xw_reg);
            end
            OP_CV:
            begin
                op_a = {2'b0, damp_reg};
                op_b = BW'(vw_reg);
            end
            OP_IM:
            begin
                op_a = {2'b0, inv_mass_reg};
                op_b = BW'(sum_reg);
            end
            OP_ADT:
            begin
                op_a = AW'(a_reg);
                op_b = BW'($signed({1'b0, dt_reg}));
            end
            default:
            begin
                op_a = AW'(vw_reg);
                op_b = BW'($signed({1'b0, dt_reg}));
            end
        endcase
    end

    // The top multiplier bit carries negative weight in two's complement.
    assign mul_last = (cnt_reg == ((op_reg == OP_ANG) ? 6'(BW - 1) : 6'(AW - 1)));
    assign p_next   = b_reg[0] ? (mul_last ? p_reg - m_reg : p_reg + m_reg) : p_reg;
    assign rnd_val  = (p_next + RND_HALF) >>> FRAC_BITS;
    assign rs       = sat32c(rnd_val);

    // angle reduction, one dividend bit per cycle
    logic [TP_W:0]          rem_sh;
    logic [TP_W-1:0]        rem_next;
    logic signed [R_W-1:0]  r0, r1, r2;
    logic                   fold_neg;

    assign rem_sh   = {rem_reg, ang_reg[ANG_W-1]};
    assign rem_next = (rem_sh >= TWO_PI_U) ? TP_W'(rem_sh - TWO_PI_U) : rem_sh[TP_W-1:0];
    assign r0       = $signed({1'b0, rem_next});
    assign r1       = (r0 >= PI_S) ? r0 - TWO_PI_S : r0;

    always_comb
    begin
        priority if (r1 > HALF_S)
        begin
            r2       = r1 - PI_S;
            fold_neg = 1'b1;
        end
        else if (r1 < -HALF_S)
        begin
            r2       = r1 + PI_S;
            fold_neg = 1'b1;
        end
        else
        begin
            r2       = r1;
            fold_neg = 1'b0;
        end
    end

    // CORDIC rotation, one iteration per cycle
    logic signed [ZW-1:0] cdx, cdy, cat, cx_next, cy_next, cz_next, c_rnd, c_clamp;
    logic                 cord_last;

    assign cdx = cy_reg >>> cnt_reg;
    assign cdy = cx_reg >>> cnt_reg;
    assign cat = $signed({4'b0, rk4do_pkg::atan_q30(cnt_reg[4:0])});
    assign cx_next = (cz_reg >= 0) ? cx_reg - cdx : cx_reg + cdx;
    assign cy_next = (cz_reg >= 0) ? cy_reg + cdy : cy_reg - cdy;
    assign cz_next = (cz_reg >= 0) ? cz_reg - cat : cz_reg + cat;
    assign cord_last = (cnt_reg == 6'(NSTEP - 1));
    assign c_rnd = (cx_next + COS_RND) >>> (30 - FRAC_BITS);

    always_comb
    begin
        priority if (c_rnd > ONE_Q)
            c_clamp = ONE_Q;
        else if (c_rnd < -ONE_Q)
            c_clamp = -ONE_Q;
        else
            c_clamp = c_rnd;
    end

    // RK4 combination and update
    logic                   w_two;
    logic signed [SUM_W-1:0] kx_add, kv_add;
    logic signed [31:0]     kx_half, kv_half;
    rk4do_pkg::sat_t        sx_next, sv_next, sum_sat;
    logic signed [ACC_W-1:0] acc_sum;

    assign w_two   = (stage_reg == 2'd1) || (stage_reg == 2'd2);
    assign kx_add  = w_two ? SUM_W'(rs.val) <<< 1 : SUM_W'(rs.val);
    assign kv_add  = w_two ? SUM_W'(kv_reg) <<< 1 : SUM_W'(kv_reg);
    assign kx_half = (stage_reg == 2'd2) ? rs.val : rs.val >>> 1;
    assign kv_half = (stage_reg == 2'd2) ? kv_reg : kv_reg >>> 1;
    assign sx_next = sat32c(PW'(pos_reg) + PW'(kx_half));
    assign sv_next = sat32c(PW'(vel_reg) + PW'(kv_half));
    assign acc_sum = acc_reg - ACC_W'(rnd_val) + ACC_W'(force_reg);
    assign sum_sat = sat32c(PW'(acc_sum));

    // truncating division by six, one quotient bit per cycle
    logic [3:0]             rx_sh, rv_sh;
    logic                   qx_bit, qv_bit, div_last;
    logic [SUM_W-1:0]       qx_abs, qv_abs;
    logic signed [SUM_W:0]  qx, qv;
    rk4do_pkg::sat_t        pos_fin, vel_fin;

    assign rx_sh    = {remx_reg, divx_reg[SUM_W-1]};
    assign rv_sh    = {remv_reg, divv_reg[SUM_W-1]};
    assign qx_bit   = (rx_sh >= 4'd6);
    assign qv_bit   = (rv_sh >= 4'd6);
    assign div_last = (cnt_reg == 6'(SUM_W - 1));
    assign qx_abs   = {divx_reg[SUM_W-2:0], qx_bit};
    assign qv_abs   = {divv_reg[SUM_W-2:0], qv_bit};
    assign qx       = negx_reg ? -$signed({1'b0, qx_abs}) : $signed({1'b0, qx_abs});
    assign qv       = negv_reg ? -$signed({1'b0, qv_abs}) : $signed({1'b0, qv_abs});
    assign pos_fin  = sat32c(PW'(pos_reg) + PW'(qx));
    assign vel_fin  = sat32c(PW'(vel_reg) + PW'(qv));

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_mass_reg  <= rk4do_pkg::RST_INV_MASS;
            stiff_reg     <= rk4do_pkg::RST_STIFFNESS;
            damp_reg      <= rk4do_pkg::RST_DAMPING;
            f_amp_reg     <= rk4do_pkg::RST_F_AMP;
            f_freq_reg    <= rk4do_pkg::RST_F_FREQ;
            dt_reg        <= rk4do_pkg::RST_TIME_STEP;
            init_pos_reg  <= rk4do_pkg::RST_INIT_POS;
            init_vel_reg  <= rk4do_pkg::RST_INIT_VEL;
            pos_reg       <= rk4do_pkg::RST_INIT_POS;
            vel_reg       <= rk4do_pkg::RST_INIT_VEL;
            sim_time_reg  <= '0;
            countdown_reg <= '0;
            clip_flag_reg <= 1'b0;
            state_reg     <= S_IDLE;
            op_reg        <= OP_ANG;
            stage_reg     <= '0;
            sample_reg    <= 1'b0;
            step_clip_reg <= 1'b0;
            tm_reg        <= '0;
            te_reg        <= '0;
            ts_reg        <= '0;
            xw_reg        <= '0;
            vw_reg        <= '0;
            force_reg     <= '0;
            sum_reg       <= '0;
            a_reg         <= '0;
            kv_reg        <= '0;
            acc_reg       <= '0;
            sumx_reg      <= '0;
            sumv_reg      <= '0;
            negx_reg      <= 1'b0;
            negv_reg      <= 1'b0;
            divx_reg      <= '0;
            divv_reg      <= '0;
            remx_reg      <= '0;
            remv_reg      <= '0;
            cnt_reg       <= '0;
            m_reg         <= '0;
            p_reg         <= '0;
            b_reg         <= '0;
            ang_reg       <= '0;
            rem_reg       <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            cz_reg        <= '0;
            cos_reg       <= '0;
            cneg_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_sat_reg   <= 1'b0;
            out_time_reg  <= '0;
            out_pos_reg   <= '0;
            out_vel_reg   <= '0;
            out_force_reg <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_idx)
                    rk4do_pkg::REG_INV_MASS:  inv_mass_reg <= pwdata[30:0];
                    rk4do_pkg::REG_STIFFNESS: stiff_reg    <= pwdata[30:0];
                    rk4do_pkg::REG_DAMPING:   damp_reg     <= pwdata[30:0];
                    rk4do_pkg::REG_F_AMP:     f_amp_reg    <= pwdata;
                    rk4do_pkg::REG_F_FREQ:    f_freq_reg   <= pwdata[30:0];
                    rk4do_pkg::REG_TIME_STEP: dt_reg       <= pwdata[24:0];
                    rk4do_pkg::REG_INIT_POS:  init_pos_reg <= pwdata;
                    rk4do_pkg::REG_INIT_VEL:  init_vel_reg <= pwdata;
                endcase
            end

            // In S_OUT the output register is reloaded below instead.
            if (out_valid_reg && m_axis_tready && state_reg != S_OUT)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && restart)
                    begin
                        pos_reg       <= init_pos_reg;
                        vel_reg       <= init_vel_reg;
                        sim_time_reg  <= '0;
                        countdown_reg <= '0;
                        clip_flag_reg <= 1'b0;
                    end
                    else if (in_acc)
                    begin
                        sample_reg    <= (countdown_reg == '0);
                        countdown_reg <= (countdown_reg == '0) ?
                                         rk4do_pkg::CNT_W'(SAMPLE_EVERY - 1) :
                                         countdown_reg - 1'b1;
                        step_clip_reg <= tm_sum[40] || te_sum[40];
                        tm_reg        <= tm_sum[40] ? '1 : tm_sum[39:0];
                        te_reg        <= te_sum[40] ? '1 : te_sum[39:0];
                        ts_reg        <= sim_time_reg;
                        xw_reg        <= pos_reg;
                        vw_reg        <= vel_reg;
                        stage_reg     <= '0;
                        sumx_reg      <= '0;
                        sumv_reg      <= '0;
                        op_reg        <= OP_ANG;
                        state_reg     <= S_LOAD;
                    end
                end

                S_LOAD:
                begin
                    m_reg     <= PW'(op_a);
                    b_reg     <= op_b;
                    p_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_MUL;
                end

                S_MUL:
                begin
                    p_reg   <= p_next;
                    m_reg   <= m_reg <<< 1;
                    b_reg   <= b_reg >>> 1;
                    if (!mul_last)
                        cnt_reg <= cnt_reg + 1'b1;
                    if (mul_last)
                    begin
                        unique case (op_reg)
                            OP_ANG:
                            begin
                                ang_reg   <= p_next[FRAC_BITS +: ANG_W];
                                rem_reg   <= '0;
                                cnt_reg   <= '0;
                                state_reg <= S_MOD;
                            end
                            OP_FRC:
                            begin
                                force_reg     <= rs.val;
                                step_clip_reg <= step_clip_reg | rs.clip;
                                op_reg        <= OP_KX;
                                // The stage-one force is the force at the sample time.
                                state_reg     <= (stage_reg == '0 && sample_reg) ?
                                                 S_OUT : S_LOAD;
                            end
                            OP_KX:
                            begin
                                acc_reg   <= -ACC_W'(rnd_val);
                                op_reg    <= OP_CV;
                                state_reg <= S_LOAD;
                            end
                            OP_CV:
                            begin
                                sum_reg       <= sum_sat.val;
                                step_clip_reg <= step_clip_reg | sum_sat.clip;
                                op_reg        <= OP_IM;
                                state_reg     <= S_LOAD;
                            end
                            OP_IM:
                            begin
                                a_reg         <= rs.val;
                                step_clip_reg <= step_clip_reg | rs.clip;
                                op_reg        <= OP_ADT;
                                state_reg     <= S_LOAD;
                            end
                            OP_ADT:
                            begin
                                kv_reg        <= rs.val;
                                step_clip_reg <= step_clip_reg | rs.clip;
                                op_reg        <= OP_VDT;
                                state_reg     <= S_LOAD;
                            end
                            default:
                            begin
                                sumx_reg <= sumx_reg + kx_add;
                                sumv_reg <= sumv_reg + kv_add;
                                if (stage_reg == 2'd3)
                                begin
                                    step_clip_reg <= step_clip_reg | rs.clip;
                                    negx_reg  <= sumx_reg[SUM_W-1] ^ kx_add[SUM_W-1] ?
                                                 (sumx_reg + kx_add) < 0 :
                                                 sumx_reg[SUM_W-1];
                                    negv_reg  <= (sumv_reg + kv_add) < 0;
                                    divx_reg  <= ((sumx_reg + kx_add) < 0) ?
                                                 SUM_W'(-(sumx_reg + kx_add)) :
                                                 SUM_W'(sumx_reg + kx_add);
                                    divv_reg  <= ((sumv_reg + kv_add) < 0) ?
                                                 SUM_W'(-(sumv_reg + kv_add)) :
                                                 SUM_W'(sumv_reg + kv_add);
                                    remx_reg  <= '0;
                                    remv_reg  <= '0;
                                    cnt_reg   <= '0;
                                    state_reg <= S_DIV;
                                end
                                else
                                begin
                                    step_clip_reg <= step_clip_reg | rs.clip |
                                                     sx_next.clip | sv_next.clip;
                                    xw_reg    <= sx_next.val;
                                    vw_reg    <= sv_next.val;
                                    ts_reg    <= (stage_reg == 2'd2) ? te_reg : tm_reg;
                                    stage_reg <= stage_reg + 1'b1;
                                    op_reg    <= OP_ANG;
                                    state_reg <= S_LOAD;
                                end
                            end
                        endcase
                    end
                end

                S_MOD:
                begin
                    rem_reg <= rem_next;
                    ang_reg <= ang_reg << 1;
                    if (cnt_reg == 6'(ANG_W - 1))
                    begin
                        cx_reg    <= $signed(rk4do_pkg::CORDIC_GAIN_Q30);
                        cy_reg    <= '0;
                        cz_reg    <= ZW'(r2) <<< (30 - FRAC_BITS);
                        cneg_reg  <= fold_neg;
                        cnt_reg   <= '0;
                        state_reg <= S_CORD;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end

                S_CORD:
                begin
                    cx_reg  <= cx_next;
                    cy_reg  <= cy_next;
                    cz_reg  <= cz_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cord_last)
                    begin
                        cos_reg   <= cneg_reg ? -c_clamp : c_clamp;
                        op_reg    <= OP_FRC;
                        state_reg <= S_LOAD;
                    end
                end

                S_OUT:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_time_reg  <= sim_time_reg;
                        out_pos_reg   <= pos_reg;
                        out_vel_reg   <= vel_reg;
                        out_force_reg <= force_reg;
                        out_sat_reg   <= clip_flag_reg;
                        state_reg     <= S_LOAD;
                    end
                end

                S_DIV:
                begin
                    divx_reg <= qx_abs;
                    divv_reg <= qv_abs;
                    remx_reg <= qx_bit ? 3'(rx_sh - 4'd6) : rx_sh[2:0];
                    remv_reg <= qv_bit ? 3'(rv_sh - 4'd6) : rv_sh[2:0];
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (div_last)
                    begin
                        pos_reg       <= pos_fin.val;
                        vel_reg       <= vel_fin.val;
                        sim_time_reg  <= te_reg;
                        clip_flag_reg <= step_clip_reg | pos_fin.clip | vel_fin.clip |
                                         (clip_flag_reg && !sample_reg);
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_sat_reg, out_force_reg, out_vel_reg,
                            out_pos_reg, out_time_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `RK4DO_ASSERT_IMP(a_countdown_range, 1'b1,
        countdown_reg <= rk4do_pkg::CNT_W'(SAMPLE_EVERY - 1),
        "sample countdown above its reload value")
    `RK4DO_ASSERT_NXT(a_restart_clears, s_axis_tvalid && s_axis_tready && s_axis_tdata[0],
        sim_time_reg == '0 && countdown_reg == '0 && !clip_flag_reg,
        "restart did not clear time, countdown and clip flag")
    `RK4DO_ASSERT_IMP(a_out_from_sample, $rose(out_valid_reg),
        $past(state_reg == S_OUT) && sample_reg,
        "output word raised outside a sampled step")
    `RK4DO_ASSERT_IMP(a_div_last_stage, state_reg == S_DIV,
        stage_reg == 2'd3,
        "final division entered before the fourth stage")

endmodule

### dv/rk4_driven_damped_oscillator_unit_tb.sv
// ----------------------------------------------------------------------------
// RK4 driven damped oscillator unit testbench
// Drives restart and step words through the input stream, predicts every
// sample word with a fixed-point model of the RK4 step and checks it field by
// field. The APB registers are rewritten between phases while the unit idles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rk4_driven_damped_oscillator_unit_tb;

    localparam int  SAMPLE_EVERY = 100;
    localparam int  FB           = 24;
    localparam int  SETTLE       = 1500;
    localparam int  WATCHDOG     = 30000;
    localparam int  N_ITEMS      = 400;

    typedef struct {
        logic [39:0]        tm;
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] frc;
        logic               sat;
    } sample_t;

    class osc_scoreboard;
        longint inv_mass, stiff, damp, f_amp, f_freq, dt_reg, init_pos, init_vel;
        longint pos, vel, sim_t;
        int     countdown;
        bit     clip_flag, clip_now;
        int     errors;
        sample_t samples_due[$];
        longint atan_tab[24];
        longint two_pi, pi_c, half_pi;

        function new();
            atan_tab = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                         64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                         64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                         64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
                         64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                         64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
            two_pi  = longint'((rk4do_pkg::TWO_PI_Q32 + 64'd128) >> 8);
            pi_c    = longint'((rk4do_pkg::PI_Q32 + 64'd128) >> 8);
            half_pi = longint'((rk4do_pkg::HALF_PI_Q32 + 64'd128) >> 8);
            inv_mass = longint'(rk4do_pkg::RST_INV_MASS);
            stiff    = longint'(rk4do_pkg::RST_STIFFNESS);
            damp     = longint'(rk4do_pkg::RST_DAMPING);
            f_amp    = longint'(rk4do_pkg::RST_F_AMP);
            f_freq   = longint'(rk4do_pkg::RST_F_FREQ);
            dt_reg   = longint'(rk4do_pkg::RST_TIME_STEP);
            init_pos = longint'(rk4do_pkg::RST_INIT_POS);
            init_vel = longint'(rk4do_pkg::RST_INIT_VEL);
            pos = init_pos;
            vel = init_vel;
            sim_t = 0;
            countdown = 0;
            clip_flag = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                rk4do_pkg::REG_INV_MASS:  inv_mass = longint'(v[30:0]);
                rk4do_pkg::REG_STIFFNESS: stiff    = longint'(v[30:0]);
                rk4do_pkg::REG_DAMPING:   damp     = longint'(v[30:0]);
                rk4do_pkg::REG_F_AMP:     f_amp    = longint'(signed'(v));
                rk4do_pkg::REG_F_FREQ:    f_freq   = longint'(v[30:0]);
                rk4do_pkg::REG_TIME_STEP: dt_reg   = longint'(v[24:0]);
                rk4do_pkg::REG_INIT_POS:  init_pos = longint'(signed'(v));
                rk4do_pkg::REG_INIT_VEL:  init_vel = longint'(signed'(v));
                default: ;
            endcase
        endfunction

        function longint rnd(longint v);
            return (v + (longint'(1) <<< (FB - 1))) >>> FB;
        endfunction

        function longint sat(longint v);
            if (v > 64'sd2147483647) begin
                clip_now = 1;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648) begin
                clip_now = 1;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function longint time_add(longint t, longint d);
            longint s;
            s = t + d;
            if (s > 64'hFF_FFFF_FFFF) begin
                clip_now = 1;
                return 64'hFF_FFFF_FFFF;
            end
            return s;
        endfunction

        function longint cosine(longint t);
            longint ang, r, x, y, z, dx, dy, c;
            bit neg;
            ang = f_freq * (t >> FB) + ((f_freq * (t & ((longint'(1) << FB) - 1))) >> FB);
            r = ang % two_pi;
            neg = 0;
            if (r >= pi_c)
                r -= two_pi;
            if (r > half_pi) begin
                r -= pi_c;
                neg = 1;
            end else if (r < -half_pi) begin
                r += pi_c;
                neg = 1;
            end
            z = r * (longint'(1) << (30 - FB));
            x = longint'(rk4do_pkg::CORDIC_GAIN_Q30);
            y = 0;
            for (int i = 0; i < 24; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx;
                    y += dy;
                    z -= atan_tab[i];
                end else begin
                    x += dx;
                    y -= dy;
                    z += atan_tab[i];
                end
            end
            c = (x + (longint'(1) <<< (29 - FB))) >>> (30 - FB);
            if (c > (longint'(1) << FB))
                c = longint'(1) << FB;
            if (c < -(longint'(1) << FB))
                c = -(longint'(1) << FB);
            return neg ? -c : c;
        endfunction

        function longint force_at(longint t);
            return sat(rnd(f_amp * cosine(t)));
        endfunction

        function longint accel(longint t, longint x, longint v);
            longint f, s;
            f = force_at(t);
            s = sat(-rnd(stiff * x) - rnd(damp * v) + f);
            return sat(rnd(inv_mass * s));
        endfunction

        // Called for every word taken on the input stream.
        function void note_word(bit restart);
            longint kx[4], kv[4];
            longint x, v, dt, xw, vw, tmid, tend;
            sample_t s;
            bit keep;
            if (restart) begin
                pos = init_pos;
                vel = init_vel;
                sim_t = 0;
                countdown = 0;
                clip_flag = 0;
                return;
            end
            dt = dt_reg;
            x = pos;
            v = vel;
            if (countdown == 0) begin
                keep = clip_now;
                s.tm  = sim_t[39:0];
                s.pos = pos[31:0];
                s.vel = vel[31:0];
                s.frc = 32'(force_at(sim_t));
                s.sat = clip_flag;
                clip_now = keep;
                samples_due.push_back(s);
                clip_flag = 0;
                countdown = SAMPLE_EVERY - 1;
            end else begin
                countdown--;
            end
            clip_now = 0;
            tmid = time_add(sim_t, dt >>> 1);
            tend = time_add(sim_t, dt);
            kx[0] = sat(rnd(v * dt));
            kv[0] = sat(rnd(accel(sim_t, x, v) * dt));
            for (int j = 1; j < 3; j++) begin
                xw = sat(x + (kx[j-1] >>> 1));
                vw = sat(v + (kv[j-1] >>> 1));
                kx[j] = sat(rnd(vw * dt));
                kv[j] = sat(rnd(accel(tmid, xw, vw) * dt));
            end
            xw = sat(x + kx[2]);
            vw = sat(v + kv[2]);
            kx[3] = sat(rnd(vw * dt));
            kv[3] = sat(rnd(accel(tend, xw, vw) * dt));
            pos = sat(x + (kx[0] + 2 * kx[1] + 2 * kx[2] + kx[3]) / 6);
            vel = sat(v + (kv[0] + 2 * kv[1] + 2 * kv[2] + kv[3]) / 6);
            sim_t = time_add(sim_t, dt);
            if (clip_now)
                clip_flag = 1;
        endfunction

        function void check_word(logic [143:0] w);
            sample_t e;
            if (samples_due.size() == 0) begin
                $error("sample word with none expected: %0h", w);
                errors++;
                return;
            end
            e = samples_due.pop_front();
            if (w[39:0] !== e.tm) begin
                $error("sample_time: expected %0h, got %0h", e.tm, w[39:0]);
                errors++;
            end
            if (w[71:40] !== e.pos) begin
                $error("position: expected %0h, got %0h", e.pos, w[71:40]);
                errors++;
            end
            if (w[103:72] !== e.vel) begin
                $error("velocity: expected %0h, got %0h", e.vel, w[103:72]);
                errors++;
            end
            if (w[135:104] !== e.frc) begin
                $error("force_res: expected %0h, got %0h", e.frc, w[135:104]);
                errors++;
            end
            if (w[136] !== e.sat) begin
                $error("saturated: expected %0h, got %0h", e.sat, w[136]);
                errors++;
            end
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 8'd0;      // [0] restart, [7:1] zero
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [143:0] m_axis_tdata;             // [39:0] time, [71:40] position,
                                            // [103:72] velocity, [135:104] force,
                                            // [136] saturated
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [rk4do_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0]  pwdata = 32'd0;
    logic [31:0]  prdata;
    logic         pready;

    osc_scoreboard sb = new();
    int  idle_cycles = 0;
    int  sink_stall = 0;
    int  words_sent = 0;
    bit  calm = 0;

    always #6 clk = ~clk;

    rk4_driven_damped_oscillator_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    always @(posedge clk) begin
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_word(m_axis_tdata);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)
                    || (psel && penable))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    always @(posedge clk) begin
        if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            m_axis_tready <= 1'b0;
        end else begin
            sink_stall <= pick_gap();
            m_axis_tready <= 1'b1;
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= rk4do_pkg::ADDR_W'(idx) << 2;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.write_reg(idx, v);
    endtask

    // Holds tvalid high across back-to-back words; lowers it only for a gap.
    task automatic send_word(bit restart);
        int g;
        g = pick_gap();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, restart};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_word(restart);
        words_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.samples_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Mostly a restart followed by a short run, so each run yields a sample.
    task automatic run_traffic(int n);
        int target, k;
        target = words_sent + n;
        while (words_sent < target) begin
            if ($urandom_range(0, 9) < 8) begin
                send_word(1'b1);
                k = ($urandom_range(0, 39) == 0) ? $urandom_range(100, 103)
                                                 : $urandom_range(1, 4);
                repeat (k) send_word(1'b0);
            end else begin
                send_word(1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic load_regs(logic [31:0] im, logic [31:0] k, logic [31:0] c,
                             logic [31:0] fa, logic [31:0] fw, logic [31:0] dt,
                             logic [31:0] x0, logic [31:0] v0);
        cfg_write(rk4do_pkg::REG_INV_MASS, im);
        cfg_write(rk4do_pkg::REG_STIFFNESS, k);
        cfg_write(rk4do_pkg::REG_DAMPING, c);
        cfg_write(rk4do_pkg::REG_F_AMP, fa);
        cfg_write(rk4do_pkg::REG_F_FREQ, fw);
        cfg_write(rk4do_pkg::REG_TIME_STEP, dt);
        cfg_write(rk4do_pkg::REG_INIT_POS, x0);
        cfg_write(rk4do_pkg::REG_INIT_VEL, v0);
    endtask

    task automatic load_moderate();
        load_regs($urandom_range(1 << 22, 1 << 26), $urandom_range(0, 1 << 26),
                  $urandom_range(0, 1 << 24), $urandom - 32'h8000_0000 >>> 4,
                  $urandom_range(0, 1 << 27), $urandom_range(1, 1 << 21),
                  $urandom_range(0, 1 << 27) - (1 << 26),
                  $urandom_range(0, 1 << 27) - (1 << 26));
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: first step samples at time zero, restarts in between.
        send_word(1'b0);
        send_word(1'b0);
        send_word(1'b1);
        send_word(1'b1);
        send_word(1'b0);
        send_word(1'b0);
        send_word(1'b1);
        send_word(1'b0);
        drain();

        // Upper extremes, which force saturation, then lower ones.
        load_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h0100_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(1'b1);
        repeat (3) send_word(1'b0);
        send_word(1'b1);
        send_word(1'b0);
        drain();
        load_regs(32'h0000_0001, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h1,
                  32'h8000_0000, 32'h7FFF_FFFF);
        send_word(1'b1);
        repeat (2) send_word(1'b0);
        drain();

        load_moderate();
        run_traffic(80);
        // Let the pipeline empty once in mid-stream before going on.
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.samples_due.size() != 0)
            @(posedge clk);
        run_traffic(40);
        drain();

        load_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom);
        run_traffic(70);
        drain();

        // Zero mass inverse and zero step are taken as they stand.
        load_regs(32'h0, $urandom, $urandom, $urandom, $urandom, 32'h0,
                  $urandom, $urandom);
        run_traffic(30);
        drain();

        calm = 1;
        load_moderate();
        send_word(1'b1);
        repeat (101) send_word(1'b0);
        calm = 0;
        run_traffic(N_ITEMS - words_sent > 20 ? N_ITEMS - words_sent : 20);
        drain();

        if (sb.errors == 0 && sb.samples_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/rk4do_pkg.sv
hw/rtl/rk4_driven_damped_oscillator_unit.sv
dv/rk4_driven_damped_oscillator_unit_tb.sv
